FILE: rtl/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define CHK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// implication with overlapping consequent
`define CHK_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication with consequent in the next cycle
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bdpl_pkg.sv
// shared types and constants of the button debounce / press length block
// no dependencies
package bdpl_pkg;

    localparam int unsigned TICK_W      = 16;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [TICK_W-1:0] DEBOUNCE_TICKS_RST   = 16'd50;
    localparam logic [TICK_W-1:0] LONG_PRESS_TICKS_RST = 16'd1000;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TICKS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_TICKS = 2'd1;

    // debounce phase, one-hot
    typedef enum logic [4:0] {
        PH_INIT         = 5'b00001,
        PH_LOW_STABLE   = 5'b00010,
        PH_LOW_TESTING  = 5'b00100,
        PH_HIGH_STABLE  = 5'b01000,
        PH_HIGH_TESTING = 5'b10000
    } phase_t;

endpackage

FILE: rtl/button_debounce_press_length_core.sv
// button debouncer with short / long press detection, top level
// depends on bdpl_pkg
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  in       | sink      | in_valid/in_stall  | pin_level
//  out      | source    | out_valid/out_stall| short_press, long_press, stable_level,
//           |           |                    | settling
//  cfg      | sink      | cfg_we             | cfg_index, cfg_data
//
// one transfer in and one result out per clock while out is not stalled; an item passes
// through the input register, then the phase update feeding the result register
// the input register advances whenever the result register is empty or being taken,
// so a stall on out reaches in_stall only once both registers hold an item
// rst_n clears all control state; debounce_ticks resets to 50, long_press_ticks to 1000
// stable_level reads 1 until the first settle
module button_debounce_press_length_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                pin_level,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                short_press,
    output logic                                long_press,
    output logic                                stable_level,
    output logic                                settling,
    // configuration
    input  logic                                cfg_we,
    input  logic [bdpl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bdpl_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // configuration registers
    logic [bdpl_pkg::TICK_W-1:0] debounce_ticks_reg;
    logic [bdpl_pkg::TICK_W-1:0] long_press_ticks_reg;

    // input stage
    logic s1_valid_reg;
    logic pin_reg;
    logic in_accept;
    logic s1_adv;

    // debounce state
    bdpl_pkg::phase_t            phase_reg,       phase_next;
    logic                        previous_pin_reg;
    logic                        armed_reg,       armed_next;
    logic [bdpl_pkg::TICK_W-1:0] countdown_reg,   countdown_next;
    logic [bdpl_pkg::TICK_W-1:0] tick_now_reg;
    logic [bdpl_pkg::TICK_W-1:0] press_start_reg, press_start_next;
    logic                        level_reg,       level_next;

    // press length against threshold
    logic [bdpl_pkg::TICK_W-1:0] press_len;
    logic                        is_long;
    logic                        want_high;

    // result stage
    logic out_valid_reg;
    logic short_reg, short_next;
    logic long_reg,  long_next;
    logic stable_reg;
    logic settling_reg, settling_next;

    assign in_accept = in_valid && !in_stall;
    // input register moves on when the result register is free or draining
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && out_valid_reg && out_stall;

    // configuration writes, unused indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg   <= bdpl_pkg::DEBOUNCE_TICKS_RST;
            long_press_ticks_reg <= bdpl_pkg::LONG_PRESS_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bdpl_pkg::REG_DEBOUNCE_TICKS:   debounce_ticks_reg   <= cfg_data;
                bdpl_pkg::REG_LONG_PRESS_TICKS: long_press_ticks_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pin_reg <= pin_level;
        end
    end

    // modulo 2^16 press length and threshold compare
    assign press_len = tick_now_reg - press_start_reg;
    assign is_long   = !(press_len < long_press_ticks_reg);
    assign want_high = (phase_reg == bdpl_pkg::PH_HIGH_TESTING);

    // phase update for one tick
    always_comb
    begin
        phase_next       = phase_reg;
        armed_next       = armed_reg;
        countdown_next   = countdown_reg;
        press_start_next = press_start_reg;
        level_next       = level_reg;
        short_next       = 1'b0;
        long_next        = 1'b0;

        case (phase_reg)
            bdpl_pkg::PH_INIT:
            begin
                // first sample: test toward whatever level it shows
                phase_next     = pin_reg ? bdpl_pkg::PH_HIGH_TESTING
                                         : bdpl_pkg::PH_LOW_TESTING;
                countdown_next = debounce_ticks_reg;
            end
            bdpl_pkg::PH_LOW_STABLE:
            begin
                // rising edge only; a falling edge here is ignored
                if (pin_reg && !previous_pin_reg)
                begin
                    phase_next     = bdpl_pkg::PH_HIGH_TESTING;
                    countdown_next = debounce_ticks_reg;
                end
            end
            bdpl_pkg::PH_HIGH_STABLE:
            begin
                if (!pin_reg && previous_pin_reg)
                begin
                    phase_next     = bdpl_pkg::PH_LOW_TESTING;
                    countdown_next = debounce_ticks_reg;
                end
            end
            bdpl_pkg::PH_LOW_TESTING, bdpl_pkg::PH_HIGH_TESTING:
            begin
                if (countdown_reg > 16'd1)
                begin
                    countdown_next = countdown_reg - 16'd1;
                end
                else
                begin
                    // settle: the pin level now decides, a zero count acts as one
                    countdown_next = '0;
                    level_next     = pin_reg;
                    if (!pin_reg)
                    begin
                        phase_next = bdpl_pkg::PH_LOW_STABLE;
                        // press start only when the low test really ended low
                        if (!want_high)
                        begin
                            if (armed_reg)
                            begin
                                press_start_next = tick_now_reg;
                            end
                            else
                            begin
                                armed_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        phase_next = bdpl_pkg::PH_HIGH_STABLE;
                        // release measured only when the high test ended high
                        if (want_high)
                        begin
                            if (armed_reg)
                            begin
                                short_next = !is_long;
                                long_next  = is_long;
                            end
                            else
                            begin
                                armed_next = 1'b1;
                            end
                        end
                    end
                end
            end
            default:
            begin
                phase_next = bdpl_pkg::PH_INIT;
            end
        endcase

        settling_next = (phase_next inside {bdpl_pkg::PH_LOW_TESTING,
                                            bdpl_pkg::PH_HIGH_TESTING});
    end

    // debounce state, one tick per transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= bdpl_pkg::PH_INIT;
            previous_pin_reg <= 1'b0;
            armed_reg        <= 1'b0;
            countdown_reg    <= '0;
            tick_now_reg     <= '0;
            press_start_reg  <= '0;
            level_reg        <= 1'b1;
        end
        else if (s1_adv)
        begin
            phase_reg        <= phase_next;
            previous_pin_reg <= pin_reg;
            armed_reg        <= armed_next;
            countdown_reg    <= countdown_next;
            tick_now_reg     <= tick_now_reg + 16'd1;
            press_start_reg  <= press_start_next;
            level_reg        <= level_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            short_reg    <= short_next;
            long_reg     <= long_next;
            stable_reg   <= level_next;
            settling_reg <= settling_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign short_press  = short_reg;
    assign long_press   = long_reg;
    assign stable_level = stable_reg;
    assign settling     = settling_reg;

endmodule

FILE: rtl/bdpl_checker.sv
// port-level checker for button_debounce_press_length_core, bound to the top level
// depends on assert_macros.svh and bdpl_pkg
`include "assert_macros.svh"

module bdpl_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             pin_level,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic                             short_press,
    input logic                             long_press,
    input logic                             stable_level,
    input logic                             settling,
    input logic                             cfg_we,
    input logic [bdpl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [bdpl_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic in_xfer;
    logic cfg_any;

    assign in_xfer = in_valid && !in_stall;
    // configuration port is watched but not checked here
    assign cfg_any = cfg_we && ((cfg_index == bdpl_pkg::REG_DEBOUNCE_TICKS)
                                || (cfg_data != '0) || pin_level);

    // a stalled result holds
    `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable({short_press, long_press, stable_level, settling}), "stalled result changed")

    // input only backs up behind a stalled result
    `CHK_IMPLY(a_stall_cause, in_stall, out_valid && out_stall, "in_stall without a stalled result")

    // an accepted item reaches the output when the output drains
    `CHK_NEXT(a_latency, in_xfer ##1 (!out_valid || !out_stall), out_valid, "accepted item lost")

    // a press report comes with a settled high level and a single kind
    `CHK_IMPLY(a_press_level, out_valid && (short_press || long_press), stable_level && !settling && !(short_press && long_press) && (cfg_any || !cfg_any), "bad press report")

endmodule

bind button_debounce_press_length_core bdpl_checker u_bdpl_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pin_level    (pin_level),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .short_press  (short_press),
    .long_press   (long_press),
    .stable_level (stable_level),
    .settling     (settling),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
);
